[src/assert_macros.svh]
// Assertion macros shared by the encoder sources.
// Each macro takes a label, the clock, the reset and a condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge out of reset.
`define TTHV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tthv: assertion failed");
// The condition must never be true at a clock edge out of reset.
`define TTHV_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tthv: forbidden condition seen");
`else
`define TTHV_ASSERT(lbl, clk, rst, prop)
`define TTHV_NEVER(lbl, clk, rst, cond)
`endif
`endif

[src/tthv_pkg.sv]
package tthv_pkg;

  // Hypervector size in 64-bit words per token.
  localparam int HV_WORDS = 8;
  localparam int HV_CNT_W = (HV_WORDS > 1) ? $clog2(HV_WORDS) : 1;

  // Hash and generator constants.
  localparam logic [63:0] FNV_BASIS   = 64'd14695981039346656037;
  localparam logic [63:0] XS_FALLBACK = 64'd88172645463325252;

  // Token count ceiling and register reset values.
  localparam logic [12:0] TOKEN_CAP       = 13'd4096;
  localparam logic [12:0] MAX_TOKENS_RST  = 13'd256;
  localparam logic [7:0]  MAX_TOK_LEN_RST = 8'd63;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKEN_LEN = 1'd1;

  // Job queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Packed output beat: hv_word, word_index, token_position, token_last.
  localparam int M_TDATA_W = 80;

  // One finished token (or a bare end marker) waiting for expansion.
  typedef struct packed {
    logic [63:0] hash;
    logic [11:0] pos;
    logic        done;
    logic        bare;
  } job_t;

  // One FNV-1a step; the prime 2^40 + 0x1B3 is applied as shifted adds.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] c);
    logic [63:0] x;
    x = h ^ {56'd0, c};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[src/tthv_queue.sv]
`include "assert_macros.svh"

module tthv_queue
  import tthv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  // Entry storage, written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  `TTHV_NEVER(a_no_push_full, clk, rst, push && full)
  `TTHV_NEVER(a_no_pop_empty, clk, rst, pop && empty)
  `TTHV_ASSERT(a_count_bound, clk, rst, count <= (QPTR_W+1)'(QDEPTH))

endmodule

[src/tthv_front.sv]
`include "assert_macros.svh"

module tthv_front
  import tthv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  q_push,
  output job_t                  q_job,
  input  logic                  q_full
);

  typedef enum logic [1:0] {F_IDLE, F_PLAN, F_PUSH} fstate_t;

  fstate_t     state;
  logic [7:0]  byte_q;
  logic        has_q;
  logic        end_q;
  logic        in_word;
  logic [7:0]  tok_len;
  logic [63:0] hash;
  logic [12:0] tok_cnt;
  logic [12:0] max_tokens;
  logic [7:0]  max_len;
  logic        pend1;
  logic        pend2;
  logic        pendb;
  job_t        job1;
  job_t        job2;

  logic        valid_b;
  logic        is_space;
  logic        is_upper;
  logic        is_word;
  logic        is_other;
  logic [12:0] lim_tok;
  logic [7:0]  lim_len;
  logic [7:0]  lc;
  logic [63:0] fnv_base;
  logic [63:0] fnv_out;
  logic        w_start;
  logic [7:0]  len_new;
  logic        j1;
  logic        j2;
  logic [12:0] cnt1;
  logic        cont;
  logic        pend1_next;
  logic        pend2_next;
  logic        pendb_next;
  job_t        bare_job;

  assign s_tready  = (state == F_IDLE);
  assign cfg_ready = 1'b1;

  // Byte classes, limits and the single hash unit.
  always_comb begin
    valid_b  = has_q && (byte_q != 8'd0);
    is_space = (byte_q == 8'h20) || ((byte_q >= 8'h09) && (byte_q <= 8'h0D));
    is_upper = (byte_q >= 8'h41) && (byte_q <= 8'h5A);
    is_word  = is_upper || ((byte_q >= 8'h30) && (byte_q <= 8'h39)) ||
               ((byte_q >= 8'h61) && (byte_q <= 8'h7A)) || (byte_q == 8'h5F);
    is_other = valid_b && !is_space && !is_word;
    lim_tok  = (max_tokens > TOKEN_CAP) ? TOKEN_CAP : max_tokens;
    lim_len  = (max_len == 8'd0) ? 8'd1 : max_len;
    lc       = is_upper ? (byte_q + 8'd32) : byte_q;
    fnv_base = (is_word && in_word) ? hash : FNV_BASIS;
    fnv_out  = fnv_step(fnv_base, lc);
  end

  // Token plan for the latched item: a pending word token, a one-byte token,
  // or a bare end marker.
  always_comb begin
    w_start = valid_b && is_word && (in_word || (tok_cnt < lim_tok));
    len_new = (in_word ? tok_len : 8'd0) + 8'd1;
    j1 = (valid_b && !is_word && in_word) ||
         (w_start && ((len_new >= lim_len) || end_q)) ||
         (!valid_b && in_word && end_q);
    cnt1 = tok_cnt + {12'd0, j1};
    j2   = is_other && (cnt1 < lim_tok);
    cont = w_start && !j1;
  end

  // Push order: word token first, then the one-byte token, then the marker.
  always_comb begin
    bare_job   = '{hash: '0, pos: '0, done: 1'b1, bare: 1'b1};
    pend1_next = pend1;
    pend2_next = pend2;
    pendb_next = pendb;
    q_push     = (state == F_PUSH) && !q_full;
    priority if (pend1) begin
      q_job      = job1;
      pend1_next = 1'b0;
    end else if (pend2) begin
      q_job      = job2;
      pend2_next = 1'b0;
    end else begin
      q_job      = bare_job;
      pendb_next = 1'b0;
    end
  end

  // Front state machine, token state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      in_word    <= 1'b0;
      tok_len    <= 8'd0;
      hash       <= FNV_BASIS;
      tok_cnt    <= 13'd0;
      max_tokens <= MAX_TOKENS_RST;
      max_len    <= MAX_TOK_LEN_RST;
      pend1      <= 1'b0;
      pend2      <= 1'b0;
      pendb      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_TOKENS:    max_tokens <= cfg_data;
          CFG_MAX_TOKEN_LEN: max_len    <= cfg_data[7:0];
        endcase
      end
      unique case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            byte_q <= s_tdata;
            has_q  <= s_tuser;
            end_q  <= s_tlast;
            state  <= F_PLAN;
          end
        end
        F_PLAN: begin
          job1  <= '{hash: (w_start ? fnv_out : hash), pos: tok_cnt[11:0],
                     done: end_q && !j2, bare: 1'b0};
          job2  <= '{hash: fnv_out, pos: cnt1[11:0], done: end_q, bare: 1'b0};
          pend1 <= j1;
          pend2 <= j2;
          pendb <= end_q && !j1 && !j2;
          if (end_q) begin
            in_word <= 1'b0;
            tok_len <= 8'd0;
            hash    <= FNV_BASIS;
            tok_cnt <= 13'd0;
          end else if (valid_b) begin
            // An ignored beat leaves the pending token as it is.
            in_word <= cont;
            tok_len <= cont ? len_new : 8'd0;
            hash    <= cont ? fnv_out : FNV_BASIS;
            tok_cnt <= cnt1 + {12'd0, j2};
          end
          state <= (j1 || j2 || end_q) ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!q_full) begin
            pend1 <= pend1_next;
            pend2 <= pend2_next;
            pendb <= pendb_next;
            if (!pend1_next && !pend2_next && !pendb_next) begin
              state <= F_IDLE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `TTHV_ASSERT(a_push_has_work, clk, rst, (state == F_PUSH) |-> (pend1 || pend2 || pendb))
  `TTHV_NEVER(a_no_push_outside, clk, rst, q_push && (state != F_PUSH))
  `TTHV_ASSERT(a_cnt_bound, clk, rst, tok_cnt <= (TOKEN_CAP + 13'd1))

endmodule

[src/tthv_back.sv]
`include "assert_macros.svh"

module tthv_back
  import tthv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  job_t                 q_job,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  logic                busy;
  logic [63:0]         gen;
  logic [HV_CNT_W-1:0] widx;
  logic [11:0]         job_pos;
  logic                job_done;

  logic                out_valid;
  logic [63:0]         out_word;
  logic [2:0]          out_idx;
  logic [11:0]         out_pos;
  logic                out_wvalid;
  logic                out_last;
  logic                out_done;

  logic                out_free;
  logic                last_word;
  logic [63:0]         xs;
  logic                emit_word;
  logic                emit_bare;
  logic                load_job;

  // One xorshift64 step; a zero state is replaced first.
  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] x;
    x = (s == 64'd0) ? XS_FALLBACK : s;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

  // Word generation and job intake.
  always_comb begin
    out_free  = !out_valid || m_tready;
    last_word = (widx == HV_CNT_W'(HV_WORDS - 1));
    xs        = xorshift(gen);
    emit_word = busy && out_free;
    emit_bare = !busy && !q_empty && q_job.bare && out_free;
    load_job  = !busy && !q_empty && !q_job.bare;
    q_pop     = emit_bare || load_job;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_last, out_pos, out_idx, out_word};
  assign m_tuser  = out_wvalid;
  assign m_tlast  = out_done;

  // Generator sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_job) begin
        busy     <= 1'b1;
        gen      <= q_job.hash;
        widx     <= '0;
        job_pos  <= q_job.pos;
        job_done <= q_job.done;
      end
      if (emit_word) begin
        gen        <= xs;
        widx       <= widx + HV_CNT_W'(1);
        out_valid  <= 1'b1;
        out_word   <= xs;
        out_idx    <= 3'(widx);
        out_pos    <= job_pos;
        out_wvalid <= 1'b1;
        out_last   <= last_word;
        out_done   <= last_word && job_done;
        if (last_word) begin
          busy <= 1'b0;
        end
      end else if (emit_bare) begin
        out_valid  <= 1'b1;
        out_word   <= 64'd0;
        out_idx    <= 3'd0;
        out_pos    <= 12'd0;
        out_wvalid <= 1'b0;
        out_last   <= 1'b0;
        out_done   <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TTHV_NEVER(a_no_pop_busy, clk, rst, q_pop && busy)
  `TTHV_ASSERT(a_done_on_end, clk, rst, (out_valid && out_done && out_wvalid) |-> out_last)
  `TTHV_ASSERT(a_hold_stalled, clk, rst, (out_valid && !m_tready) |=> out_valid)

endmodule

[src/text_token_hypervector_encoder_unit.sv]
// Channel  Direction  Beat contents
// s_*      in         tdata: char_byte; tuser: has_byte; tlast: text_end
// m_*      out        tdata: hv_word, word_index, token_position, token_last;
//                     tuser: word_valid; tlast: text_done
// cfg_*    in         cfg_index selects max_tokens (0) or max_token_len (1)
//
// The front latches one input beat, plans its tokens, then pushes each job
// (tokens, then any end marker) before it accepts the next beat.
// The back handles a token as one load, then one xorshift step per output
// word; a bare end marker goes out as a single beat.
// A 4-entry job queue lets the front keep taking bytes while the back works.
// Reset is synchronous; it clears control, token and limit state, not data registers.
// m_tready low holds the output beat; the back and then the front stall.
module text_token_hypervector_encoder_unit
  import tthv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] char_byte
  input  logic                  s_tuser,   // [0] has_byte
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [63:0] hv_word, [66:64] word_index,
                                           // [78:67] token_position, [79] token_last
  output logic                  m_tuser,   // [0] word_valid
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  // Tokenizer and hasher.
  tthv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_job     (push_job),
    .q_full    (q_full)
  );

  // Job queue between the two halves.
  tthv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Hypervector word generator.
  tthv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (pop_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[tb/text_token_hypervector_encoder_unit_tb.sv]
`timescale 1ns / 1ps

module text_token_hypervector_encoder_unit_tb;
  import tthv_pkg::*;

  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [7:0] ASCII_TAB = 8'h09;
  localparam logic [7:0] ASCII_CR = 8'h0D;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 25;
  localparam int FINAL_WAIT_CYCLES = 50000;

  // One output beat as the block should produce it.
  typedef struct packed {
    logic [63:0] hv_word;
    logic [2:0]  word_index;
    logic [11:0] token_position;
    logic        word_valid;
    logic        token_last;
    logic        text_done;
  } hv_beat_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hv_beat_t expected_words[$];
  int mismatch_count = 0;
  int useful_items = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  // Encoder state mirrored by the testbench.
  logic        in_word;
  logic [7:0]  tok_len;
  logic [63:0] tok_hash;
  logic [12:0] tok_count;
  logic [63:0] gen_state;
  logic [12:0] max_tokens_reg;
  logic [7:0]  max_len_reg;

  text_token_hypervector_encoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Byte classes in the C locale.
  function automatic logic is_space_byte(input logic [7:0] b);
    return (b == " ") || (b >= ASCII_TAB && b <= ASCII_CR);
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || (b == "_");
  endfunction

  function automatic logic [63:0] xorshift_next(input logic [63:0] s);
    logic [63:0] x;
    x = (s == 64'd0) ? XS_FALLBACK : s;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

  function automatic void reset_encoder_state();
    in_word = 1'b0;
    tok_len = 8'd0;
    tok_hash = FNV_BASIS;
    tok_count = 13'd0;
    gen_state = 64'd0;
    max_tokens_reg = MAX_TOKENS_RST;
    max_len_reg = MAX_TOK_LEN_RST;
  endfunction

  // Expand the finished token hash into its hypervector words.
  function automatic void emit_token_words();
    hv_beat_t w;
    gen_state = tok_hash;
    for (int i = 0; i < HV_WORDS; i++) begin
      gen_state = xorshift_next(gen_state);
      w.hv_word = gen_state;
      w.word_index = 3'(i);
      w.token_position = tok_count[11:0];
      w.word_valid = 1'b1;
      w.token_last = (i == HV_WORDS - 1);
      w.text_done = 1'b0;
      expected_words.push_back(w);
    end
    tok_count = tok_count + 13'd1;
    in_word = 1'b0;
    tok_len = 8'd0;
    tok_hash = FNV_BASIS;
  endfunction

  // Work out the words that one accepted input beat produces.
  function automatic void encode_beat(input logic [7:0] b, input logic has, input logic fin);
    int before_n;
    logic [12:0] lim_tokens;
    logic [7:0] lim_len;
    logic [7:0] c;
    hv_beat_t w;
    before_n = expected_words.size();
    lim_tokens = (max_tokens_reg > TOKEN_CAP) ? TOKEN_CAP : max_tokens_reg;
    lim_len = (max_len_reg == 8'd0) ? 8'd1 : max_len_reg;
    c = (b >= "A" && b <= "Z") ? b + ("a" - "A") : b;

    if (has && b != 8'h00) begin
      if (is_space_byte(b)) begin
        if (in_word) emit_token_words();
      end else if (is_word_byte(b)) begin
        if (!in_word && tok_count < lim_tokens) begin
          in_word = 1'b1;
          tok_len = 8'd0;
          tok_hash = FNV_BASIS;
        end
        if (in_word) begin
          tok_hash = (tok_hash ^ {56'd0, c}) * FNV_PRIME;
          tok_len = tok_len + 8'd1;
          if (tok_len >= lim_len) emit_token_words();
        end
      end else begin
        // Any other byte closes a pending word and, under the token limit, is a token by itself.
        if (in_word) emit_token_words();
        if (tok_count < lim_tokens) begin
          tok_hash = (FNV_BASIS ^ {56'd0, b}) * FNV_PRIME;
          emit_token_words();
        end
      end
    end

    if (fin) begin
      if (in_word) emit_token_words();
      if (expected_words.size() == before_n) begin
        w = '0;
        expected_words.push_back(w);
      end
      w = expected_words.pop_back();
      w.text_done = 1'b1;
      expected_words.push_back(w);
      in_word = 1'b0;
      tok_len = 8'd0;
      tok_hash = FNV_BASIS;
      tok_count = 13'd0;
    end
  endfunction

  // Predict on every input beat the block takes.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) encode_beat(s_tdata, s_tuser, s_tlast);
  end

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Compare each output beat with the oldest expected word.
  always @(posedge clk) begin : word_checker
    hv_beat_t want;
    hv_beat_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.hv_word = m_tdata[63:0];
      got.word_index = m_tdata[66:64];
      got.token_position = m_tdata[78:67];
      got.token_last = m_tdata[79];
      got.word_valid = m_tuser;
      got.text_done = m_tlast;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      end else begin
        want = expected_words.pop_front();
        check_field("hv_word", want.hv_word, got.hv_word);
        check_field("word_index", 64'(want.word_index), 64'(got.word_index));
        check_field("token_position", 64'(want.token_position), 64'(got.token_position));
        check_field("word_valid", 64'(want.word_valid), 64'(got.word_valid));
        check_field("token_last", 64'(want.token_last), 64'(got.token_last));
        check_field("text_done", 64'(want.text_done), 64'(got.text_done));
      end
    end
  end

  // Output ready: random stalls, plus a long hold-off on request.
  initial begin : ready_driver
    int run_left;
    m_tready = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (!idle_on || $urandom_range(0, 99) < 60) begin
        m_tready <= 1'b1;
        run_left = idle_on ? $urandom_range(0, 12) : 0;
      end else begin
        m_tready <= 1'b0;
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] rand_other_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (is_space_byte(b) || is_word_byte(b)) b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  function automatic logic [7:0] rand_space_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? " " : ASCII_TAB + 8'(r);
  endfunction

  // Offer one input beat after a random gap and wait until it is taken.
  task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= has;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if ((has && b != 8'h00) || fin) useful_items++;
  endtask

  task automatic send_text(input string txt, input logic close);
    for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b1, close && (i == txt.len() - 1));
  endtask

  task automatic stream_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Stop sending, wait for every expected word, then let the front settle.
  task automatic drain();
    stream_idle();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MAX_TOKENS) max_tokens_reg = data;
    else max_len_reg = data[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [12:0] tokens, input logic [12:0] len_data);
    drain();
    write_reg(CFG_MAX_TOKENS, tokens);
    write_reg(CFG_MAX_TOKEN_LEN, len_data);
  endtask

  // Every byte class, class boundaries, ignored beats and end-of-text forms.
  task automatic test_byte_classes();
    send_text("Ab_9 ", 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item("Z", 1'b0, 1'b0);
    send_text("09AZaz_!", 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("/:@[`{", 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h08, 1'b1, 1'b0);
    send_item(8'h0E, 1'b1, 1'b0);
    send_text("\tq,\n\v\f\r~", 1'b0);
    send_item("a", 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(" ", 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_text("x~", 1'b1);
  endtask

  // Word tokens split at the length limit, including its extremes.
  task automatic test_token_length();
    set_limits(13'd256, 13'd1);
    send_text("ab c", 1'b1);
    set_limits(13'd256, 13'd0);
    send_text("xy", 1'b1);
    set_limits(13'd256, 13'h1F03);
    send_text("abcdefg hi", 1'b1);
    set_limits(13'd256, 13'd255);
    for (int i = 0; i < 24; i++) send_item(rand_word_char(), 1'b1, i == 23);
  endtask

  // Tokens past the per-text limit are dropped; the count restarts per text.
  task automatic test_token_limit();
    set_limits(13'd0, 13'd63);
    send_text("ab, c", 1'b1);
    set_limits(13'd1, 13'd63);
    send_text("ab!cd", 1'b1);
    send_text("ef", 1'b1);
    set_limits(13'd1, 13'd2);
    send_text("abc", 1'b1);
    set_limits(13'd2, 13'd63);
    send_text("a b c! d", 1'b1);
    set_limits(13'd8191, 13'd63);
    send_text("one two", 1'b1);
    set_limits(13'd4096, 13'd4);
    send_text("tok_limit!", 1'b1);
  endtask

  // Output held off for a long stretch while input keeps coming.
  task automatic test_backpressure();
    set_limits(MAX_TOKENS_RST, 13'(MAX_TOK_LEN_RST));
    idle_on = 1'b0;
    hold_request = 1'b1;
    send_text("the quick, brown fox! jumps over_it", 1'b1);
    idle_on = 1'b1;
    drain();
  endtask

  // Random texts: mostly well formed, some raw noise, limits changed between texts.
  task automatic test_random_texts();
    int goal;
    int n_tok;
    int kind;
    int len;
    goal = useful_items + RANDOM_ITEMS;
    while (useful_items < goal) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: set_limits(MAX_TOKENS_RST, 13'(MAX_TOK_LEN_RST));
          1: set_limits(13'($urandom_range(1, 6)), 13'($urandom_range(2, 6)));
          2: set_limits(13'($urandom_range(0, 3)), 13'($urandom_range(0, 3)));
          3: set_limits(13'($urandom_range(4096, 8191)), 13'($urandom_range(1, 255)));
          default: set_limits(13'($urandom_range(1, 4096)), 13'($urandom_range(0, 8191)));
        endcase
      end
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), i == len - 1);
      end else begin
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++) begin
          kind = $urandom_range(0, 19);
          if (kind < 14) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send_item(rand_word_char(), 1'b1, 1'b0);
          end else if (kind < 17) begin
            send_item(rand_other_byte(), 1'b1, 1'b0);
          end else if (kind < 18) begin
            send_item(8'h00, 1'b1, 1'b0);
          end else begin
            send_item(8'($urandom_range(1, 255)), 1'b0, 1'b0);
          end
          if ($urandom_range(0, 3) != 0) send_item(rand_space_byte(), 1'b1, 1'b0);
        end
        case ($urandom_range(0, 2))
          0: send_item(8'h00, 1'b0, 1'b1);
          1: send_item(rand_word_char(), 1'b1, 1'b1);
          default: send_item(rand_space_byte(), 1'b1, 1'b1);
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : stimulus
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_TOKENS;
    cfg_data = '0;
    reset_encoder_state();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_byte_classes();
    test_token_length();
    test_token_limit();
    test_backpressure();
    test_random_texts();

    // Let the last words come out, with a bound.
    stream_idle();
    waited = 0;
    while (expected_words.size() != 0 && waited < FINAL_WAIT_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      mismatch_count += expected_words.size();
      $display("%0t: %0d expected words never arrived, expected %h, actual none",
               $time, expected_words.size(), expected_words[0]);
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tthv_pkg.sv
src/tthv_queue.sv
src/tthv_front.sv
src/tthv_back.sv
src/text_token_hypervector_encoder_unit.sv
tb/text_token_hypervector_encoder_unit_tb.sv
